// ===== rtl/core/iwdg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Independent watchdog package
// Shared widths, key words, register codes and types for the watchdog core.
// ----------------------------------------------------------------------------
package iwdg_pkg;

  // Width of the watchdog down-counter and the reload register.
  localparam int COUNT_WIDTH = 12;
  // Width of the bus write data and of the read data and count result fields.
  localparam int DATA_W      = 16;
  localparam int OUT_W       = 12;
  localparam int CODE_W      = 3;
  localparam int DIV_CNT_W   = 8;
  localparam int DIV_W       = DIV_CNT_W + 1;

  localparam logic [DATA_W-1:0] KEY_UNLOCK = 16'h5555;
  localparam logic [DATA_W-1:0] KEY_RELOAD = 16'hAAAA;
  localparam logic [DATA_W-1:0] KEY_START  = 16'hCCCC;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ADDR_KEY      = 2'd0,
    ADDR_PRESCALE = 2'd1,
    ADDR_RELOAD   = 2'd2,
    ADDR_STATUS   = 2'd3
  } addr_e;

  // One accepted transaction from the input side.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    addr_e             addr;
    mode_e             mode;
  } item_t;

  // Control handed from the register block to the counter block.
  typedef struct packed {
    logic                   tick;
    logic                   running;
    logic [CODE_W-1:0]      prescale_code;
    logic                   load;
    logic [COUNT_WIDTH-1:0] reload_value;
  } ctrl_t;

  // Division ratio for a prescaler code: 4 << code, saturated at 256.
  function automatic logic [DIV_W-1:0] div_of_code(input logic [CODE_W-1:0] code);
    logic [DIV_W-1:0] d;
    begin
      case (code)
        3'd0:    d = DIV_W'(4);
        3'd1:    d = DIV_W'(8);
        3'd2:    d = DIV_W'(16);
        3'd3:    d = DIV_W'(32);
        3'd4:    d = DIV_W'(64);
        3'd5:    d = DIV_W'(128);
        default: d = DIV_W'(256);
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/iwdg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Watchdog register block
// Key lock, start flag, prescaler and reload registers with pending copies.
// ----------------------------------------------------------------------------
module iwdg_regs (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire iwdg_pkg::item_t       item_i,
  input  wire logic                  expire_i,
  output iwdg_pkg::ctrl_t            ctrl_o,
  output logic [iwdg_pkg::OUT_W-1:0] read_data_o
);

  logic                                running_q, running_d;
  logic                                unlocked_q, unlocked_d;
  logic [iwdg_pkg::CODE_W-1:0]         prescale_q, prescale_d;
  logic [iwdg_pkg::COUNT_WIDTH-1:0]    reload_q, reload_d;
  logic                                pre_busy_q, pre_busy_d;
  logic [iwdg_pkg::CODE_W-1:0]         pre_code_q, pre_code_d;
  logic                                rld_busy_q, rld_busy_d;
  logic [iwdg_pkg::COUNT_WIDTH-1:0]    rld_val_q, rld_val_d;
  logic                                tick;
  logic                                load;

  assign tick = step_i && (item_i.mode == iwdg_pkg::MODE_TICK);

  always_comb begin
    running_d   = running_q;
    unlocked_d  = unlocked_q;
    prescale_d  = prescale_q;
    reload_d    = reload_q;
    pre_busy_d  = pre_busy_q;
    pre_code_d  = pre_code_q;
    rld_busy_d  = rld_busy_q;
    rld_val_d   = rld_val_q;
    load        = 1'b0;
    read_data_o = '0;
    if (step_i) begin
      case (item_i.mode)
        iwdg_pkg::MODE_WRITE: begin
          case (item_i.addr)
            iwdg_pkg::ADDR_KEY: begin
              if (item_i.data == iwdg_pkg::KEY_UNLOCK) begin
                unlocked_d = 1'b1;
              end else begin
                unlocked_d = 1'b0;
                if (item_i.data == iwdg_pkg::KEY_RELOAD) begin
                  load = 1'b1;
                end else if (item_i.data == iwdg_pkg::KEY_START) begin
                  running_d = 1'b1;
                end
              end
            end
            iwdg_pkg::ADDR_PRESCALE: begin
              if (unlocked_q) begin
                pre_busy_d = 1'b1;
                pre_code_d = item_i.data[iwdg_pkg::CODE_W-1:0];
              end
            end
            iwdg_pkg::ADDR_RELOAD: begin
              if (unlocked_q) begin
                rld_busy_d = 1'b1;
                rld_val_d  = item_i.data[iwdg_pkg::COUNT_WIDTH-1:0];
              end
            end
            default: ;
          endcase
        end
        iwdg_pkg::MODE_READ: begin
          case (item_i.addr)
            iwdg_pkg::ADDR_PRESCALE: read_data_o = iwdg_pkg::OUT_W'(prescale_q);
            iwdg_pkg::ADDR_RELOAD:   read_data_o = iwdg_pkg::OUT_W'(reload_q);
            iwdg_pkg::ADDR_STATUS:   read_data_o = iwdg_pkg::OUT_W'({rld_busy_q, pre_busy_q});
            default:                 read_data_o = '0;
          endcase
        end
        iwdg_pkg::MODE_TICK: begin
          // Pending values land on the tick before the divider looks at them.
          if (pre_busy_q) begin
            prescale_d = pre_code_q;
            pre_busy_d = 1'b0;
            pre_code_d = '0;
          end
          if (rld_busy_q) begin
            reload_d   = rld_val_q;
            rld_busy_d = 1'b0;
            rld_val_d  = '0;
          end
        end
        default: ;
      endcase
      if (expire_i) begin
        running_d  = 1'b0;
        unlocked_d = 1'b0;
        prescale_d = '0;
        reload_d   = '1;
        pre_busy_d = 1'b0;
        pre_code_d = '0;
        rld_busy_d = 1'b0;
        rld_val_d  = '0;
      end
    end
  end

  always_comb begin
    ctrl_o.tick          = tick;
    ctrl_o.running       = running_q;
    ctrl_o.prescale_code = (tick && pre_busy_q) ? pre_code_q : prescale_q;
    ctrl_o.load          = load;
    ctrl_o.reload_value  = reload_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      unlocked_q <= 1'b0;
      prescale_q <= '0;
      reload_q   <= '1;
      pre_busy_q <= 1'b0;
      pre_code_q <= '0;
      rld_busy_q <= 1'b0;
      rld_val_q  <= '0;
    end else begin
      running_q  <= running_d;
      unlocked_q <= unlocked_d;
      prescale_q <= prescale_d;
      reload_q   <= reload_d;
      pre_busy_q <= pre_busy_d;
      pre_code_q <= pre_code_d;
      rld_busy_q <= rld_busy_d;
      rld_val_q  <= rld_val_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/iwdg_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Watchdog counter
// Prescale divider and down-counter with expiry detection.
// ----------------------------------------------------------------------------
module iwdg_counter (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire iwdg_pkg::ctrl_t       ctrl_i,
  output logic                       expire_o,
  output logic [iwdg_pkg::OUT_W-1:0] count_now_o,
  output logic [iwdg_pkg::COUNT_WIDTH-1:0] count_o
);

  logic [iwdg_pkg::DIV_CNT_W-1:0]   div_q, div_d;
  logic [iwdg_pkg::COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [iwdg_pkg::DIV_W-1:0]       div_next;
  logic                             wrap;
  logic                             at_end;

  assign div_next = {1'b0, div_q} + iwdg_pkg::DIV_W'(1);
  assign wrap     = div_next >= iwdg_pkg::div_of_code(ctrl_i.prescale_code);
  assign at_end   = cnt_q <= iwdg_pkg::COUNT_WIDTH'(1);
  assign expire_o = step_i && ctrl_i.tick && ctrl_i.running && wrap && at_end;

  always_comb begin
    div_d = div_q;
    cnt_d = cnt_q;
    if (step_i) begin
      if (ctrl_i.load) begin
        cnt_d = ctrl_i.reload_value;
      end
      if (ctrl_i.tick && ctrl_i.running) begin
        if (wrap) begin
          div_d = '0;
          if (!at_end) begin
            cnt_d = cnt_q - iwdg_pkg::COUNT_WIDTH'(1);
          end
        end else begin
          div_d = div_next[iwdg_pkg::DIV_CNT_W-1:0];
        end
      end
      if (expire_o) begin
        div_d = '0;
        cnt_d = '1;
      end
    end
  end

  assign count_now_o = expire_o ? '0 : iwdg_pkg::OUT_W'(cnt_d);
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
      cnt_q <= '1;
    end else begin
      div_q <= div_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/independent_watchdog_regs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Independent watchdog register core
// Key, prescaler, reload and status registers around a prescaled down-counter.
// ----------------------------------------------------------------------------
// Each input transaction is a bus write, a bus read, one tick of the
// watchdog clock or a no-op, selected by the mode in s_axis_tuser. Every input
// transaction produces exactly one output transaction carrying the read data,
// the reset flag and the counter value after the operation. A transaction is
// captured in an input register, processed by the register block and the
// counter once the output register can take its result, and its result is
// written to the output register, so the core takes one transaction per cycle
// while the sink is ready. The result is offered from the output register
// after its transaction is processed. While the output register waits on the
// sink, the input register holds its transaction and the input side stalls.
// The rate is set by the single register update of the watchdog state
// per transaction. Writing key 0x5555
// unlocks the prescaler and reload registers, 0xAAAA reloads the counter,
// 0xCCCC starts the watchdog, and any other key locks again. Unlocked writes
// become effective on the next tick, with a busy bit visible in status until
// then. When the running counter expires, reset is flagged in the result and
// all state returns to its reset values.
// ----------------------------------------------------------------------------
module independent_watchdog_regs_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] write_data
  input  wire logic [3:0]  s_axis_tuser,  // [1:0] mode, [3:2] reg_addr
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // [11:0] read_data, [12] reset_out,
                                          // [24:13] count_now, [31:25] zero
);

  iwdg_pkg::item_t                  in_q;
  logic                             in_valid_q, in_valid_d;
  logic [31:0]                      out_q, out_d;
  logic                             out_valid_q, out_valid_d;
  logic                             advance;
  logic                             accept;
  iwdg_pkg::ctrl_t                  ctrl;
  logic                             expire;
  logic [iwdg_pkg::OUT_W-1:0]       read_data;
  logic [iwdg_pkg::OUT_W-1:0]       count_now;
  logic [iwdg_pkg::COUNT_WIDTH-1:0] count;

  // The held transaction moves on whenever the output register is empty or
  // its contents are being taken in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);
  assign out_d         = {7'd0, count_now, expire, read_data};

  iwdg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .expire_i    (expire),
    .ctrl_o      (ctrl),
    .read_data_o (read_data)
  );

  iwdg_counter u_counter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .ctrl_i      (ctrl),
    .expire_o    (expire),
    .count_now_o (count_now),
    .count_o     (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.mode <= iwdg_pkg::mode_e'(s_axis_tuser[1:0]);
      in_q.addr <= iwdg_pkg::addr_e'(s_axis_tuser[3:2]);
      in_q.data <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // A result that reports expiry always shows a cleared counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[24:13] == '0)
    else $error("expiry result with nonzero count");

  // After an expiry the counter is back at its reset value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && expire |=> count == '1)
    else $error("counter not restored after expiry");

  // A processed transaction always leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed transaction produced no result");

  // Expiry only happens on a watchdog clock tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    expire |-> in_q.mode == iwdg_pkg::MODE_TICK)
    else $error("expiry outside a tick");

endmodule

`default_nettype wire
